// ===== sv/drive_command_safety_gate_defines.svh =====
// Assertion macros used by the drive command safety gate checker.
`ifndef DRIVE_COMMAND_SAFETY_GATE_DEFINES_SVH
`define DRIVE_COMMAND_SAFETY_GATE_DEFINES_SVH

// Clocked check of an implication, disabled while reset is asserted.
`define DCSG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Clocked check of a next-cycle implication, disabled while reset is asserted.
`define DCSG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/dcsg_pkg.sv =====
// Types and constants of the drive command safety gate.
package dcsg_pkg;

	localparam int unsigned ElapsedW = 17;
	localparam logic [ElapsedW-1:0] ELAPSED_MAX = '1;

	localparam logic [7:0] MAX_STOP_REASON = 8'd3;
	localparam logic [7:0] ECHO_MAX_LEN    = 8'd64;
	localparam logic [7:0] SEQ_HALF        = 8'd128;
	localparam logic [7:0] DRIVE_LEN       = 8'd5;
	localparam logic [7:0] STOP_LEN        = 8'd1;
	localparam logic [7:0] RESET_LEN       = 8'd4;

	localparam logic [15:0] TIMEOUT_RESET = 16'd500;

	// register indexes
	localparam logic [1:0] REG_MAX_SPEED     = 2'd0;
	localparam logic [1:0] REG_MAX_STEERING  = 2'd1;
	localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

	// item kinds
	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [2:0] KIND_DRIVE = 3'd0;
	localparam logic [2:0] KIND_STOP  = 3'd1;
	localparam logic [2:0] KIND_RESET = 3'd2;
	localparam logic [2:0] KIND_ECHO  = 3'd3;

	typedef enum logic [2:0] {
		ST_ACCEPT     = 3'd0,
		ST_INVALID    = 3'd1,
		ST_REARM      = 3'd2,
		ST_UNCONFIG   = 3'd3,
		ST_DUP_SEQ    = 3'd4,
		ST_UNKNOWN    = 3'd5,
		ST_NO_EVENT   = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_DRIVE   = 3'd1,
		ACT_STOP    = 3'd2,
		ACT_FAULT   = 3'd3,
		ACT_ECHO    = 3'd4,
		ACT_TIMEOUT = 3'd5
	} action_t;

	typedef struct packed {
		logic [14:0] max_speed;
		logic [14:0] max_steering;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [7:0]          last_seq;
		logic                seq_known;
		logic                timed_out;
		logic                rearm;
		logic [ElapsedW-1:0] elapsed;
	} gate_state_t;

	typedef struct packed {
		logic        op;
		logic [2:0]  msg_kind;
		logic [7:0]  seq_number;
		logic [7:0]  payload_len;
		logic [31:0] payload_word;
		logic [7:0]  payload_byte4;
	} item_t;

	typedef struct packed {
		status_t            status;
		action_t            action;
		logic signed [15:0] speed;
		logic signed [15:0] steering;
		logic               enable;
		logic [31:0]        value;
	} result_t;

endpackage

// ===== sv/dcsg_cfg.sv =====
// Configuration registers: speed and steering limits, timeout length.
module dcsg_cfg (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	output dcsg_pkg::cfg_t cfg
);

	dcsg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed     <= '0;
			cfg_q.max_steering  <= '0;
			cfg_q.timeout_ticks <= dcsg_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dcsg_pkg::REG_MAX_SPEED:     cfg_q.max_speed     <= cfg_data[14:0];
				dcsg_pkg::REG_MAX_STEERING:  cfg_q.max_steering  <= cfg_data[14:0];
				dcsg_pkg::REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data;
				default: ; // unused index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/dcsg_eval.sv =====
// Per-item decision logic: frame checks, sequence window, watchdog tick.
module dcsg_eval (
	input  dcsg_pkg::cfg_t        cfg,
	input  dcsg_pkg::gate_state_t st,
	input  dcsg_pkg::item_t       item,
	output dcsg_pkg::gate_state_t nxt,
	output dcsg_pkg::result_t     res
);

	logic signed [15:0] spd;
	logic signed [15:0] str;
	logic [15:0] spd_abs;
	logic [15:0] str_abs;
	logic neutral;
	logic configured;
	logic in_limits;
	logic [7:0] seq_diff;
	logic seq_ok;
	logic [dcsg_pkg::ElapsedW-1:0] el_inc;
	logic fire;

	assign spd     = item.payload_word[15:0];
	assign str     = item.payload_word[31:16];
	// 16-bit magnitude; the most negative value maps to 0x8000, still correct unsigned
	assign spd_abs = spd[15] ? 16'(-spd) : spd;
	assign str_abs = str[15] ? 16'(-str) : str;
	assign neutral = (item.payload_byte4 == 8'd0) && (spd == 16'sd0) && (str == 16'sd0);
	assign configured = (cfg.max_speed != '0) && (cfg.max_steering != '0);
	assign in_limits  = (spd_abs <= {1'b0, cfg.max_speed})
		&& (str_abs <= {1'b0, cfg.max_steering});

	// forward window: difference mod 256 in 1..127
	assign seq_diff = item.seq_number - st.last_seq;
	assign seq_ok   = !st.seq_known
		|| ((seq_diff != 8'd0) && (seq_diff < dcsg_pkg::SEQ_HALF));

	assign el_inc = (st.elapsed == dcsg_pkg::ELAPSED_MAX) ? st.elapsed
		: st.elapsed + dcsg_pkg::ElapsedW'(1);
	assign fire   = el_inc > {1'b0, cfg.timeout_ticks};

	always_comb begin
		nxt          = st;
		res.status   = dcsg_pkg::ST_NO_EVENT;
		res.action   = dcsg_pkg::ACT_NONE;
		res.speed    = '0;
		res.steering = '0;
		res.enable   = 1'b0;
		res.value    = '0;
		if (item.op == dcsg_pkg::OP_TICK) begin
			if (!st.timed_out) begin
				nxt.elapsed = el_inc;
				if (fire) begin
					nxt.timed_out = 1'b1;
					nxt.rearm     = 1'b1;
					nxt.seq_known = 1'b0;
					res.action    = dcsg_pkg::ACT_TIMEOUT;
				end
			end
		end else begin
			case (item.msg_kind)
				dcsg_pkg::KIND_DRIVE: begin
					if (item.payload_len != dcsg_pkg::DRIVE_LEN || item.payload_byte4 > 8'd1)
						res.status = dcsg_pkg::ST_INVALID;
					else if (st.rearm && !neutral)
						res.status = dcsg_pkg::ST_REARM;
					else if (!neutral && !configured)
						res.status = dcsg_pkg::ST_UNCONFIG;
					else if (!neutral && (item.payload_byte4 == 8'd0 || !in_limits))
						res.status = dcsg_pkg::ST_INVALID;
					else if (!seq_ok)
						res.status = dcsg_pkg::ST_DUP_SEQ;
					else begin
						res.status    = dcsg_pkg::ST_ACCEPT;
						res.action    = dcsg_pkg::ACT_DRIVE;
						res.speed     = spd;
						res.steering  = str;
						res.enable    = item.payload_byte4[0];
						nxt.last_seq  = item.seq_number;
						nxt.seq_known = 1'b1;
						nxt.elapsed   = '0;
						nxt.timed_out = 1'b0;
						nxt.rearm     = 1'b0;
					end
				end
				dcsg_pkg::KIND_STOP: begin
					if (item.payload_len != dcsg_pkg::STOP_LEN
						|| item.payload_word[7:0] > dcsg_pkg::MAX_STOP_REASON)
						res.status = dcsg_pkg::ST_INVALID;
					else if (!seq_ok)
						res.status = dcsg_pkg::ST_DUP_SEQ;
					else begin
						res.status    = dcsg_pkg::ST_ACCEPT;
						res.action    = dcsg_pkg::ACT_STOP;
						res.value     = {24'd0, item.payload_word[7:0]};
						nxt.last_seq  = item.seq_number;
						nxt.seq_known = 1'b1;
						nxt.rearm     = 1'b1;
					end
				end
				dcsg_pkg::KIND_RESET: begin
					if (item.payload_len != dcsg_pkg::RESET_LEN)
						res.status = dcsg_pkg::ST_INVALID;
					else if (!seq_ok)
						res.status = dcsg_pkg::ST_DUP_SEQ;
					else begin
						res.status    = dcsg_pkg::ST_ACCEPT;
						res.action    = dcsg_pkg::ACT_FAULT;
						res.value     = item.payload_word;
						nxt.last_seq  = item.seq_number;
						nxt.seq_known = 1'b1;
					end
				end
				dcsg_pkg::KIND_ECHO: begin
					if (item.payload_len > dcsg_pkg::ECHO_MAX_LEN)
						res.status = dcsg_pkg::ST_INVALID;
					else if (!seq_ok)
						res.status = dcsg_pkg::ST_DUP_SEQ;
					else begin
						res.status    = dcsg_pkg::ST_ACCEPT;
						res.action    = dcsg_pkg::ACT_ECHO;
						res.value     = {24'd0, item.seq_number};
						nxt.last_seq  = item.seq_number;
						nxt.seq_known = 1'b1;
					end
				end
				default: res.status = dcsg_pkg::ST_UNKNOWN;
			endcase
		end
	end

endmodule

// ===== sv/drive_command_safety_gate.sv =====
// Top level of the drive command safety gate: handshake, state and result registers.
//
// Drive command safety gate. Each input item is either a decoded command frame
// (op = 0) or a one-millisecond tick (op = 1), and each one yields exactly one
// result item. An accepted item is held in the input register, then the
// decision logic writes the result register and updates the gate state in
// the same edge. A new item is accepted every cycle; throughput is one item
// per clock, limited only by the downstream stall, which backs up through the
// result register into the input register. Drive frames are checked for
// length, enable byte, rearm latch, configured limits (both limits nonzero)
// and the absolute speed and steering limits; stop frames for length and
// reason range, fault-reset and echo frames for length; every frame that
// passes must also lie in the forward sequence window (1..127 ahead, mod 256)
// once a sequence is known. Ticks advance a saturating 17-bit elapsed
// counter; passing timeout_ticks forces a neutral drive, sets the rearm latch
// and forgets the sequence. After reset the gate is timed out and needs
// rearm. Configuration writes take effect at once and belong in idle periods.
module drive_command_safety_gate (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [2:0]         msg_kind,
	input  logic [7:0]         seq_number,
	input  logic [7:0]         payload_len,
	input  logic [31:0]        payload_word,
	input  logic [7:0]         payload_byte4,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [2:0]         action,
	output logic signed [15:0] speed_out,
	output logic signed [15:0] steering_out,
	output logic               enable_out,
	output logic [31:0]        action_value,
	output logic               is_timed_out,
	output logic               needs_rearm
);

	dcsg_pkg::cfg_t        cfg;
	dcsg_pkg::item_t       item_s1;
	logic                  valid_s1;
	dcsg_pkg::gate_state_t state_q;
	dcsg_pkg::gate_state_t state_nxt;
	dcsg_pkg::result_t     res;
	dcsg_pkg::result_t     res_q;
	logic                  out_valid_q;
	logic                  timed_out_q;
	logic                  rearm_q;
	logic                  adv;
	logic                  in_acc;

	dcsg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// result register free, or being drained this cycle
	assign adv      = !out_valid_q || !out_stall;
	// input register holds only when it cannot move on
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.op            <= op;
			item_s1.msg_kind      <= msg_kind;
			item_s1.seq_number    <= seq_number;
			item_s1.payload_len   <= payload_len;
			item_s1.payload_word  <= payload_word;
			item_s1.payload_byte4 <= payload_byte4;
		end
	end

	dcsg_eval u_eval (
		.cfg  (cfg),
		.st   (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	// gate state commits when the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.last_seq  <= '0;
			state_q.seq_known <= 1'b0;
			state_q.timed_out <= 1'b1;
			state_q.rearm     <= 1'b1;
			state_q.elapsed   <= '0;
			out_valid_q       <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_q       <= res;
			timed_out_q <= state_nxt.timed_out;
			rearm_q     <= state_nxt.rearm;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign action       = res_q.action;
	assign speed_out    = res_q.speed;
	assign steering_out = res_q.steering;
	assign enable_out   = res_q.enable;
	assign action_value = res_q.value;
	assign is_timed_out = timed_out_q;
	assign needs_rearm  = rearm_q;

endmodule

// ===== sv/dcsg_sva.sv =====
// Port-level checker for the drive command safety gate, bound to the top level.
`include "drive_command_safety_gate_defines.svh"

module dcsg_sva (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [2:0]         status,
	input logic [2:0]         action,
	input logic signed [15:0] speed_out,
	input logic signed [15:0] steering_out,
	input logic               enable_out,
	input logic [31:0]        action_value,
	input logic               is_timed_out,
	input logic               needs_rearm
);

	// accepted drive always leaves the gate armed and out of timeout
	`DCSG_ASSERT_IMP(a_drive_clears, out_valid && action == dcsg_pkg::ACT_DRIVE, status == dcsg_pkg::ST_ACCEPT && !is_timed_out && !needs_rearm, "drive result with bad status or flags")

	// timeout emits a neutral command and latches both flags
	`DCSG_ASSERT_IMP(a_timeout_neutral, out_valid && action == dcsg_pkg::ACT_TIMEOUT, is_timed_out && needs_rearm && speed_out == 16'sd0 && steering_out == 16'sd0 && !enable_out && action_value == 32'd0, "timeout result not neutral")

	// no action means an empty command
	`DCSG_ASSERT_IMP(a_none_empty, out_valid && action == dcsg_pkg::ACT_NONE, speed_out == 16'sd0 && steering_out == 16'sd0 && !enable_out && action_value == 32'd0, "rejected item carries a command")

	// stalled result item is held
	`DCSG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(action) && $stable(action_value), "stalled result item changed")

endmodule

bind drive_command_safety_gate dcsg_sva u_dcsg_sva (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.action       (action),
	.speed_out    (speed_out),
	.steering_out (steering_out),
	.enable_out   (enable_out),
	.action_value (action_value),
	.is_timed_out (is_timed_out),
	.needs_rearm  (needs_rearm)
);
